FILE: design/cilp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_pkg
// shared types and constants of the c integer literal parser
// ----------------------------------------------------------------------------
package cilp_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned OutWidth      = 32;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_SIGN   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_HEXPFX = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    BASE_NONE = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_t;

  typedef struct packed {
    phase_t phase;
    base_t  base;
    logic   neg;
    logic   bad;
  } ctl_t;

  localparam ctl_t CtlReset = '{phase: PH_START, base: BASE_NONE, neg: 1'b0, bad: 1'b0};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] value;
    logic                       error;
  } out_t;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch1     = 8'h31;
  localparam logic [7:0] Ch7     = 8'h37;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChLoX   = 8'h78;

endpackage

FILE: design/cilp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cilp_step
// next-state and result logic for one character of a literal
// ----------------------------------------------------------------------------
module cilp_step #(
  parameter int unsigned VALUE_WIDTH = cilp_pkg::ValueWidthDef
) (
  input  cilp_pkg::ctl_t         ctl_cur,
  input  logic [VALUE_WIDTH-1:0] acc_cur,
  input  cilp_pkg::in_t          item,
  output cilp_pkg::ctl_t         ctl_upd,
  output logic [VALUE_WIDTH-1:0] acc_upd,
  output cilp_pkg::out_t         result
);

  logic                          is_dec;
  logic                          is_up;
  logic                          is_lo;
  logic                          is_sign;
  logic [3:0]                    dig;
  logic                          dig_ok;
  logic                          num_start;
  logic [VALUE_WIDTH-1:0]        scaled;
  logic signed [VALUE_WIDTH-1:0] signed_val;

  always_comb begin
    is_dec  = (item.ch >= cilp_pkg::Ch0) && (item.ch <= cilp_pkg::Ch9);
    is_up   = (item.ch >= cilp_pkg::ChUpA) && (item.ch <= cilp_pkg::ChUpF);
    is_lo   = (item.ch >= cilp_pkg::ChLoA) && (item.ch <= cilp_pkg::ChLoF);
    is_sign = (item.ch == cilp_pkg::ChPlus) || (item.ch == cilp_pkg::ChMinus);
    if (is_up) begin
      dig = 4'(item.ch - cilp_pkg::ChUpA + 8'd10);
    end else if (is_lo) begin
      dig = 4'(item.ch - cilp_pkg::ChLoA + 8'd10);
    end else begin
      dig = 4'(item.ch - cilp_pkg::Ch0);
    end
    case (ctl_cur.base)
      cilp_pkg::BASE_OCT: dig_ok = is_dec && (item.ch <= cilp_pkg::Ch7);
      cilp_pkg::BASE_DEC: dig_ok = is_dec;
      cilp_pkg::BASE_HEX: dig_ok = is_dec || is_up || is_lo;
      default:            dig_ok = 1'b0;
    endcase
    case (ctl_cur.base)
      cilp_pkg::BASE_OCT: scaled = acc_cur << 3;
      cilp_pkg::BASE_HEX: scaled = acc_cur << 4;
      default:            scaled = (acc_cur << 3) + (acc_cur << 1);
    endcase
  end

  always_comb begin
    ctl_upd   = ctl_cur;
    acc_upd   = acc_cur;
    num_start = 1'b0;
    if (!ctl_cur.bad) begin
      unique case (ctl_cur.phase)
        cilp_pkg::PH_START: begin
          if (is_sign) begin
            ctl_upd.neg   = (item.ch == cilp_pkg::ChMinus);
            ctl_upd.phase = cilp_pkg::PH_SIGN;
          end else begin
            num_start = 1'b1;
          end
        end
        cilp_pkg::PH_SIGN: begin
          num_start = 1'b1;
        end
        cilp_pkg::PH_ZERO: begin
          if ((item.ch == cilp_pkg::ChLoX) || (item.ch == cilp_pkg::ChUpX)) begin
            ctl_upd.base  = cilp_pkg::BASE_HEX;
            ctl_upd.phase = cilp_pkg::PH_HEXPFX;
          end else if ((item.ch >= cilp_pkg::Ch0) && (item.ch <= cilp_pkg::Ch7)) begin
            ctl_upd.base  = cilp_pkg::BASE_OCT;
            acc_upd       = VALUE_WIDTH'(dig);
            ctl_upd.phase = cilp_pkg::PH_BODY;
          end else begin
            ctl_upd.bad = 1'b1;
          end
        end
        cilp_pkg::PH_HEXPFX, cilp_pkg::PH_BODY: begin
          if (dig_ok) begin
            acc_upd       = scaled + VALUE_WIDTH'(dig);
            ctl_upd.phase = cilp_pkg::PH_BODY;
          end else begin
            ctl_upd.bad = 1'b1;
          end
        end
        default: begin
          ctl_upd.bad = 1'b1;
        end
      endcase
      if (num_start) begin
        if (item.ch == cilp_pkg::Ch0) begin
          ctl_upd.phase = cilp_pkg::PH_ZERO;
        end else if ((item.ch >= cilp_pkg::Ch1) && (item.ch <= cilp_pkg::Ch9)) begin
          ctl_upd.base  = cilp_pkg::BASE_DEC;
          acc_upd       = VALUE_WIDTH'(dig);
          ctl_upd.phase = cilp_pkg::PH_BODY;
        end else begin
          ctl_upd.bad = 1'b1;
        end
      end
    end
  end

  // final value and error flag: the value is negated and sign-extended or truncated to the output width, zero on error
  always_comb begin
    result.error = ctl_upd.bad ||
                   !((ctl_upd.phase == cilp_pkg::PH_BODY) ||
                     (ctl_upd.phase == cilp_pkg::PH_ZERO));
    signed_val   = ctl_upd.neg ? signed'(-acc_upd) : signed'(acc_upd);
    if ((ctl_upd.phase == cilp_pkg::PH_ZERO) || result.error) begin
      result.value = '0;
    end else begin
      result.value = cilp_pkg::OutWidth'(signed_val);
    end
  end

endmodule

FILE: design/c_integer_literal_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_integer_literal_parser_unit
// streaming parser of c integer literals, one character per transaction
// ----------------------------------------------------------------------------
// the result is registered into out_data in the cycle after the final character is accepted
// throughput: one character per cycle while in_stall is low, set by the single state update stage
// in_stall is high only while a finished result waits under out_stall
// reset (rst_n low, synchronous) returns to the start of a literal, no result
// ----------------------------------------------------------------------------
module c_integer_literal_parser_unit #(
  parameter int unsigned VALUE_WIDTH = cilp_pkg::ValueWidthDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cilp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cilp_pkg::out_t out_data
);

  cilp_pkg::ctl_t         ctl_r;
  cilp_pkg::ctl_t         ctl_nxt;
  cilp_pkg::ctl_t         ctl_upd;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [VALUE_WIDTH-1:0] acc_nxt;
  logic [VALUE_WIDTH-1:0] acc_upd;
  cilp_pkg::out_t         result;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  cilp_pkg::out_t         out_data_r;
  cilp_pkg::out_t         out_data_nxt;
  logic                   accept;

  cilp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .ctl_cur(ctl_r),
    .acc_cur(acc_r),
    .item   (in_data),
    .ctl_upd(ctl_upd),
    .acc_upd(acc_upd),
    .result (result)
  );

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ctl_nxt       = ctl_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      if (in_data.last) begin
        ctl_nxt       = cilp_pkg::CtlReset;
        acc_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        ctl_nxt = ctl_upd;
        acc_nxt = acc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= cilp_pkg::CtlReset;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result pending");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last) |=> (out_valid_r && (ctl_r.phase == cilp_pkg::PH_START)))
    else $error("final character did not produce a result and restart");

  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error) |-> (out_data_r.value == '0))
    else $error("error result carries a nonzero value");

  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r.bad && !(accept && in_data.last)) |=> ctl_r.bad)
    else $error("error flag cleared inside a literal");

endmodule

FILE: bench/c_integer_literal_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_integer_literal_parser_unit_tb
// streams c integer literals through the parser one character per transaction
// and checks every parsed value and error flag against a cycle-free model of
// the literal grammar, under random sender and receiver idling
// ----------------------------------------------------------------------------
import cilp_pkg::*;

typedef logic [7:0] char_q_t[$];

class literal_scoreboard;
  phase_t      ph;
  base_t       base;
  bit          neg;
  logic [31:0] acc;
  bit          bad;
  out_t        pending_values[$];
  int          fail_count;
  int          chars_seen;
  int          literals_seen;
  int          malformed_seen;
  int          negative_seen;

  function new();
    clear_literal();
  endfunction

  function void clear_literal();
    ph   = PH_START;
    base = BASE_NONE;
    neg  = 1'b0;
    acc  = '0;
    bad  = 1'b0;
  endfunction

  // advance the literal state by one accepted character, queueing the expected result on the final one
  function void take_char(in_t t);
    logic [4:0] dv;
    logic [4:0] radix;
    out_t       res;
    chars_seen++;
    if (!bad) begin
      case (ph)
        PH_START, PH_SIGN: begin
          if (ph == PH_START && (t.ch == ChPlus || t.ch == ChMinus)) begin
            neg = (t.ch == ChMinus);
            ph  = PH_SIGN;
          end else if (t.ch == Ch0) begin
            ph = PH_ZERO;
          end else if (t.ch >= Ch1 && t.ch <= Ch9) begin
            base = BASE_DEC;
            acc  = 32'(t.ch - Ch0);
            ph   = PH_BODY;
          end else begin
            bad = 1'b1;
          end
        end
        PH_ZERO: begin
          if (t.ch == ChUpX || t.ch == ChLoX) begin
            base = BASE_HEX;
            ph   = PH_HEXPFX;
          end else if (t.ch >= Ch0 && t.ch <= Ch7) begin
            base = BASE_OCT;
            acc  = 32'(t.ch - Ch0);
            ph   = PH_BODY;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HEXPFX, PH_BODY: begin
          dv = 5'd16;
          if (t.ch >= Ch0 && t.ch <= Ch9) dv = 5'(t.ch - Ch0);
          else if (t.ch >= ChUpA && t.ch <= ChUpF) dv = 5'(t.ch - ChUpA + 8'd10);
          else if (t.ch >= ChLoA && t.ch <= ChLoF) dv = 5'(t.ch - ChLoA + 8'd10);
          case (base)
            BASE_OCT: radix = 5'd8;
            BASE_DEC: radix = 5'd10;
            BASE_HEX: radix = 5'd16;
            default:  radix = 5'd0;
          endcase
          if (dv >= radix) begin
            bad = 1'b1;
          end else begin
            acc = acc * 32'(radix) + 32'(dv);
            ph  = PH_BODY;
          end
        end
        default: bad = 1'b1;
      endcase
    end
    if (t.last) begin
      res.error = bad || !(ph == PH_BODY || ph == PH_ZERO);
      res.value = res.error ? '0 : (neg ? -acc : acc);
      literals_seen++;
      if (res.error) malformed_seen++;
      else if (neg) negative_seen++;
      pending_values.push_back(res);
      clear_literal();
    end
  endfunction

  function void check_value(out_t got);
    out_t want;
    if (pending_values.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: value %0d error %0b", got.value, got.error);
      return;
    end
    want = pending_values.pop_front();
    if (got.value !== want.value || got.error !== want.error) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: expected value %0d error %0b, got value %0d error %0b",
                 want.value, want.error, got.value, got.error);
    end
  endfunction
endclass

module c_integer_literal_parser_unit_tb;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  int  drain_cycles;
  literal_scoreboard sb;

  c_integer_literal_parser_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_value(out_data);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_char(d);
    @(negedge clk);
  endtask

  task automatic send_literal(input char_q_t s);
    in_t d;
    for (int i = 0; i < s.size(); i++) begin
      d.ch   = s[i];
      d.last = (i == s.size() - 1);
      send_char(d);
    end
  endtask

  function automatic char_q_t text_of(input string t);
    char_q_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    return s;
  endfunction

  // mostly well-formed literals, some damaged ones and some raw noise
  function automatic char_q_t make_literal();
    char_q_t s;
    int      kind;
    int      v;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(255)));
      return s;
    end
    case ($urandom_range(2))
      1: s.push_back(ChPlus);
      2: s.push_back(ChMinus);
      default: ;
    endcase
    case ($urandom_range(3))
      0: begin
        s.push_back(8'(Ch1 + $urandom_range(8)));
        repeat ($urandom_range(0, 11)) s.push_back(8'(Ch0 + $urandom_range(9)));
      end
      1: begin
        s.push_back(Ch0);
        repeat ($urandom_range(1, 11)) s.push_back(8'(Ch0 + $urandom_range(7)));
      end
      2: begin
        s.push_back(Ch0);
        s.push_back($urandom_range(1) ? ChUpX : ChLoX);
        repeat ($urandom_range(1, 9)) begin
          v = $urandom_range(15);
          if (v < 10) s.push_back(8'(Ch0 + v));
          else s.push_back(8'(($urandom_range(1) ? ChUpA : ChLoA) + v - 10));
        end
      end
      default: s.push_back(Ch0);
    endcase
    if (kind < 30) begin
      if ($urandom_range(1)) s.insert($urandom_range(s.size()), 8'($urandom_range(255)));
      else s = s[0:$urandom_range(s.size() - 1)];
    end
    return s;
  endfunction

  task automatic run_random(input int n_chars);
    char_q_t s;
    int      sent;
    sent = 0;
    while (sent < n_chars) begin
      s = make_literal();
      send_literal(s);
      sent += s.size();
    end
  endtask

  task automatic hold_receiver(input int n_cycles);
    repeat (40) @(posedge clk);
    hold_off = 1'b1;
    repeat (n_cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    char_q_t s;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    hold_off      = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 74;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed literals
    send_literal(text_of("0"));
    send_literal(text_of("-0"));
    s = {8'hFF};
    send_literal(s);
    send_literal(text_of("-"));
    s = {ChPlus, 8'h00};
    send_literal(s);
    send_literal(text_of("08"));
    send_literal(text_of("-017"));
    send_literal(text_of("0X"));
    send_literal(text_of("0xfF"));
    send_literal(text_of("1a5"));
    send_literal(text_of("+0"));
    send_literal(text_of("9"));

    run_random(500);
    send_idle_pct = 74;
    recv_idle_pct = 16;
    run_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      run_random(500);
      hold_receiver(300);
    join

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (sb.pending_values.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending_values.size() != 0) begin
      sb.fail_count++;
      $display("%0d expected results never arrived", sb.pending_values.size());
    end
    $display("covered %0d characters in %0d literals: %0d malformed, %0d negative",
             sb.chars_seen, sb.literals_seen, sb.malformed_seen, sb.negative_seen);
    $display("failures: %0d", sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/cilp_pkg.sv
design/cilp_step.sv
design/c_integer_literal_parser_unit.sv
bench/c_integer_literal_parser_unit_tb.sv
